// File: sv/stepper_position_tracker_assert.svh
// ----------------------------------------------------------------------------
// stepper_position_tracker_assert.svh
// Assertion macros shared by the stepper position tracker sources.
// ----------------------------------------------------------------------------
`ifndef STEPPER_POSITION_TRACKER_ASSERT_SVH
`define STEPPER_POSITION_TRACKER_ASSERT_SVH

// Same-cycle implication, checked on clk, muted in reset.
`define SPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, muted in reset.
`define SPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg
// Widths, command codes and phase codes of the stepper position tracker.
// ----------------------------------------------------------------------------
package spt_pkg;

  localparam int TGT_W  = 16;   // target position, signed
  localparam int STEP_W = 13;   // positions, step counts
  localparam int TOT_W  = 12;   // total travel register
  localparam int PCT_W  = 8;    // percent times two
  localparam int PROD_W = 20;   // position * 200
  localparam int QBITS  = 8;    // quotient bits produced by the divider

  localparam logic [TOT_W-1:0]  TOTAL_RESET = 12'd700;
  localparam logic [PROD_W-1:0] PCT_SCALE   = 20'd200;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 8'd200;

  typedef enum logic [1:0] {
    CMD_NONE = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_STOP = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_HOME  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_TRACK = 2'd2
  } phase_t;

  // Divider handshake: pulse in, pulse out.
  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: sv/spt_if.sv
// ----------------------------------------------------------------------------
// spt_if
// Valid/ready channels of the stepper position tracker: tick in, result out.
// ----------------------------------------------------------------------------
interface spt_in_if;
  import spt_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TGT_W-1:0]  target_position;
  logic                     motor_busy;
  logic [STEP_W-1:0]        executed_steps;
  logic                     throttle_switch;

  modport source (output valid, target_position, motor_busy, executed_steps,
                  throttle_switch, input ready);
  modport sink   (input valid, target_position, motor_busy, executed_steps,
                  throttle_switch, output ready);
endinterface

interface spt_out_if;
  import spt_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic               direction;
  logic [STEP_W-1:0]  run_steps;
  logic [PCT_W-1:0]   percent_position;
  logic               percent_valid;

  modport source (output valid, command, direction, run_steps, percent_position,
                  percent_valid, input ready);
  modport sink   (input valid, command, direction, run_steps, percent_position,
                  percent_valid, output ready);
endinterface

// File: sv/stepper_position_tracker.sv
// ----------------------------------------------------------------------------
// stepper_position_tracker
// Open-loop stepper position keeper. One word on in_ch is one control tick
// (target, motor busy, executed steps, throttle switch); each tick gives
// exactly one word on out_ch (command, direction, run steps, percent).
// cfg_we/cfg_wdata write total_steps; write only while the block is idle.
// Reset (rst_n low, synchronous) sets total_steps to 700 and the homing
// phase: the first tick issues an opening run, then ticks wait for the motor
// to go idle, then tracking starts at position zero.
// Flow: a homing or waiting tick passes ST_UPDATE and ST_DONE; a tracking
// tick passes ST_UPDATE, ST_DECIDE, ST_PCT, ST_DIV and ST_DONE, ST_DIV set by
// the 8-step serial divider that forms the percentage (skipped when travel
// is zero or below the position). in_ch.ready is low from accept until the
// result is in the output register, so a new tick waits for the last one.
// If the receiver stalls, the result waits in the output register; the
// block works the next tick meanwhile and holds it until out_ch frees.
// ----------------------------------------------------------------------------
module stepper_position_tracker
  import spt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  spt_in_if.sink            in_ch,
  spt_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [TOT_W-1:0]  cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DECIDE,
    ST_PCT,
    ST_DIV,
    ST_DONE
  } state_t;

  localparam int RB_W = STEP_W + 2;   // rebuild sum, signed

  // Control and state registers
  state_t              state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [TOT_W-1:0]    total_r;
  logic [STEP_W-1:0]   position_r, position_nxt;
  logic [STEP_W-1:0]   start_r, start_nxt;
  logic                reversing_r, reversing_nxt;
  logic                moving_up_r, moving_up_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Captured tick
  logic signed [TGT_W-1:0] tgt_r;
  logic                busy_r;
  logic [STEP_W-1:0]   done_r;
  logic                sw_r;

  // Working result
  logic [STEP_W-1:0]   clamp_r, clamp_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic                dir_r, dir_nxt;
  logic [STEP_W-1:0]   run_r, run_nxt;
  logic [PCT_W-1:0]    pct_r, pct_nxt;
  logic                pvalid_r, pvalid_nxt;

  // Output register
  cmd_t                o_cmd_r;
  logic                o_dir_r;
  logic [STEP_W-1:0]   o_run_r;
  logic [PCT_W-1:0]    o_pct_r;
  logic                o_pvalid_r;

  // Divider
  div_ctl_t            div_ctl;
  div_stat_t           div_stat;
  logic [PROD_W-1:0]   div_prod;
  logic [QBITS-1:0]    div_quo;

  logic                in_fire;
  logic                out_free;
  logic signed [TGT_W-1:0] tot_s;
  logic signed [RB_W-1:0]  rb_sum;
  logic signed [RB_W-1:0]  rb_tot;
  logic [STEP_W-1:0]   rb_pos;
  logic signed [STEP_W:0]  diff;
  logic [STEP_W-1:0]   diff_abs;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign tot_s  = $signed({{(TGT_W-TOT_W){1'b0}}, total_r});
  assign rb_tot = $signed({{(RB_W-TOT_W){1'b0}}, total_r});

  // Position rebuilt from the driver count after a stop
  assign rb_sum = moving_up_r
                ? $signed({2'b00, start_r}) + $signed({2'b00, done_r})
                : $signed({2'b00, start_r}) - $signed({2'b00, done_r});
  always_comb begin
    if (rb_sum < 0) begin
      rb_pos = '0;
    end else if (rb_sum > rb_tot) begin
      rb_pos = {1'b0, total_r};
    end else begin
      rb_pos = rb_sum[STEP_W-1:0];
    end
  end

  assign diff     = $signed({1'b0, clamp_r}) - $signed({1'b0, position_r});
  assign diff_abs = diff[STEP_W] ? STEP_W'(-diff) : diff[STEP_W-1:0];

  // position is at most total here, so 12 bits carry it
  assign div_prod = PROD_W'(position_r[TOT_W-1:0]) * PCT_SCALE;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    position_nxt  = position_r;
    start_nxt     = start_r;
    reversing_nxt = reversing_r;
    moving_up_nxt = moving_up_r;
    out_valid_nxt = out_valid_r;
    clamp_nxt     = clamp_r;
    cmd_nxt       = cmd_r;
    dir_nxt       = dir_r;
    run_nxt       = run_r;
    pct_nxt       = pct_r;
    pvalid_nxt    = pvalid_r;
    div_ctl.start = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_nxt    = CMD_NONE;
        dir_nxt    = 1'b0;
        run_nxt    = '0;
        pct_nxt    = '0;
        pvalid_nxt = 1'b0;
        case (phase_r)
          PH_HOME: begin
            cmd_nxt   = CMD_RUN;
            run_nxt   = sw_r ? ({1'b0, total_r} + STEP_W'(total_r >> 5))
                             : STEP_W'(total_r >> 2);
            phase_nxt = PH_WAIT;
            state_nxt = ST_DONE;
          end
          PH_WAIT: begin
            if (!busy_r) begin
              phase_nxt     = PH_TRACK;
              position_nxt  = '0;
              reversing_nxt = 1'b0;
            end
            state_nxt = ST_DONE;
          end
          default: begin
            // Tracking, and the unused phase code behaves the same
            if (tgt_r < 0) begin
              clamp_nxt = '0;
            end else if (tgt_r > tot_s) begin
              clamp_nxt = {1'b0, total_r};
            end else begin
              clamp_nxt = tgt_r[STEP_W-1:0];
            end
            if (reversing_r && !busy_r) begin
              position_nxt  = rb_pos;
              reversing_nxt = 1'b0;
            end
            state_nxt = ST_DECIDE;
          end
        endcase
      end
      ST_DECIDE: begin
        if (!reversing_r) begin
          if (!busy_r) begin
            if (diff != 0) begin
              moving_up_nxt = !diff[STEP_W];
              cmd_nxt       = CMD_RUN;
              dir_nxt       = !diff[STEP_W];
              run_nxt       = diff_abs;
              start_nxt     = position_r;
              position_nxt  = clamp_r;
            end
          end else if ((position_r < start_r) != (clamp_r < start_r)) begin
            // target crossed the start point of the running move
            cmd_nxt       = CMD_STOP;
            reversing_nxt = 1'b1;
          end
        end
        pvalid_nxt = 1'b1;
        state_nxt  = ST_PCT;
      end
      ST_PCT: begin
        if (total_r == '0) begin
          pct_nxt   = '0;
          state_nxt = ST_DONE;
        end else if (position_r > {1'b0, total_r}) begin
          pct_nxt   = PCT_FULL;
          state_nxt = ST_DONE;
        end else begin
          div_ctl.start = 1'b1;
          state_nxt     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          pct_nxt   = div_quo;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_HOME;
      total_r     <= TOTAL_RESET;
      position_r  <= '0;
      start_r     <= '0;
      reversing_r <= 1'b0;
      moving_up_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      position_r  <= position_nxt;
      start_r     <= start_nxt;
      reversing_r <= reversing_nxt;
      moving_up_r <= moving_up_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        total_r <= cfg_wdata;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      tgt_r  <= in_ch.target_position;
      busy_r <= in_ch.motor_busy;
      done_r <= in_ch.executed_steps;
      sw_r   <= in_ch.throttle_switch;
    end
    clamp_r  <= clamp_nxt;
    cmd_r    <= cmd_nxt;
    dir_r    <= dir_nxt;
    run_r    <= run_nxt;
    pct_r    <= pct_nxt;
    pvalid_r <= pvalid_nxt;
    if (state_r == ST_DONE && out_free) begin
      o_cmd_r    <= cmd_r;
      o_dir_r    <= dir_r;
      o_run_r    <= run_r;
      o_pct_r    <= pct_r;
      o_pvalid_r <= pvalid_r;
    end
  end

  spt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_prod),
    .divisor  (total_r),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_ch.valid            = out_valid_r;
  assign out_ch.command          = o_cmd_r;
  assign out_ch.direction        = o_dir_r;
  assign out_ch.run_steps        = o_run_r;
  assign out_ch.percent_position = o_pct_r;
  assign out_ch.percent_valid    = o_pvalid_r;

  `include "stepper_position_tracker_assert.svh"

  `SPT_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ch.ready,
                   "input taken again right after accept")
  `SPT_ASSERT_NOW(a_run_fields_clear,
                  out_ch.valid && (out_ch.command != CMD_RUN),
                  !out_ch.direction && (out_ch.run_steps == '0),
                  "direction or run steps set without run command")
  `SPT_ASSERT_NOW(a_pct_gated, out_ch.valid && !out_ch.percent_valid,
                  out_ch.percent_position == '0,
                  "percent reported outside tracking")
  `SPT_ASSERT_NOW(a_pct_range, out_ch.valid, out_ch.percent_position <= PCT_FULL,
                  "percent above full scale")
  `SPT_ASSERT_NOW(a_div_idle_outside, div_stat.busy,
                  (state_r == ST_DIV) && !in_ch.ready,
                  "divider running outside its wait state")

endmodule

// File: sv/spt_div.sv
// ----------------------------------------------------------------------------
// spt_div
// Restoring shift-subtract divider, one quotient bit per cycle. The caller
// guarantees dividend < divisor * 2^QBITS, so QBITS steps give the quotient.
// ----------------------------------------------------------------------------
module spt_div
  import spt_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  div_ctl_t          ctl,
  input  logic [PROD_W-1:0] dividend,
  input  logic [TOT_W-1:0]  divisor,
  output div_stat_t         stat,
  output logic [QBITS-1:0]  quotient
);

  localparam int CNT_W = $clog2(QBITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QBITS - 1);

  logic                busy_r;
  logic                done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [TOT_W-1:0]    rem_r;
  logic [QBITS-1:0]    low_r;
  logic [QBITS-1:0]    quo_r;

  logic [TOT_W:0]      trial;
  logic                ge;
  logic [TOT_W:0]      diff;

  assign trial = {rem_r, low_r[QBITS-1]};
  assign ge    = (trial >= {1'b0, divisor});
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == CNT_LAST);
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath, no reset needed.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= dividend[PROD_W-1:QBITS];
      low_r <= dividend[QBITS-1:0];
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TOT_W-1:0] : trial[TOT_W-1:0];
      low_r <= {low_r[QBITS-2:0], 1'b0};
      quo_r <= {quo_r[QBITS-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stepper position tracker. A shadow tracker
// predicts each result word from the accepted tick word. The bench covers
// homing, the waiting ticks, clamped tracking, stop on reversal with a rebuild
// from the executed-step count, and several travel settings. Random idles run
// on both channels, and one long receiver stall fills the block.
// ----------------------------------------------------------------------------
module testbench;
  import spt_pkg::*;

  localparam int CYCLE_LIMIT   = 200000; // far beyond the slowest legal run
  localparam int SETTLE_CYCLES = 16;     // idle wait before a travel write and at the end

  // Expected content of one result word.
  typedef struct {
    cmd_t               command;
    logic               direction;
    logic [STEP_W-1:0]  run_steps;
    logic [PCT_W-1:0]   percent;
    logic               percent_valid;
  } tick_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [TOT_W-1:0]  cfg_wdata;

  spt_in_if  in_ch ();
  spt_out_if out_ch ();

  stepper_position_tracker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Shadow copy of the tracker state and of the travel register.
  phase_t             mdl_phase;
  logic [STEP_W-1:0]  kept_pos;      // kept position, or target of the motion
  logic [STEP_W-1:0]  move_start;    // position where the motion began
  logic               stop_pending;  // stop sent, waiting to rebuild
  logic               heading_up;    // direction of the current motion
  logic [TOT_W-1:0]   travel;

  tick_result_t awaited[$];          // result words not yet seen, oldest first

  bit  steady;                       // no idles on either side while set
  int  hold_len;                     // one-off long receiver stall, in cycles
  int  fail_count;
  int  ticks_sent;
  int  words_seen;
  int  stops_issued;
  int  travel_writes;
  int  cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Next result word for one tick; advances the shadow state.
  function automatic tick_result_t track_tick(input logic signed [TGT_W-1:0] tgt,
                                              input logic busy,
                                              input logic [STEP_W-1:0] done,
                                              input logic sw);
    tick_result_t r;
    int span;
    int goal;
    int rebuilt;
    int diff;
    r = '{CMD_NONE, 1'b0, '0, '0, 1'b0};
    span = int'(travel);
    case (mdl_phase)
      PH_HOME: begin
        // Open toward zero: quarter travel, or full travel plus 1/32 margin.
        r.command = CMD_RUN;
        r.run_steps = sw ? STEP_W'(span + span / 32) : STEP_W'(span / 4);
        mdl_phase = PH_WAIT;
      end
      PH_WAIT: begin
        if (!busy) begin
          mdl_phase = PH_TRACK;
          kept_pos = '0;
          stop_pending = 1'b0;
        end
      end
      default: begin
        goal = int'(tgt);
        if (goal < 0) goal = 0;
        if (goal > span) goal = span;
        // After a stop, the real position comes from the driver's count.
        if (stop_pending && !busy) begin
          rebuilt = heading_up ? int'(move_start) + int'(done)
                               : int'(move_start) - int'(done);
          if (rebuilt < 0) rebuilt = 0;
          if (rebuilt > span) rebuilt = span;
          kept_pos = STEP_W'(rebuilt);
          stop_pending = 1'b0;
        end
        if (!stop_pending) begin
          diff = goal - int'(kept_pos);
          if (!busy) begin
            if (diff != 0) begin
              heading_up = diff > 0;
              r.command = CMD_RUN;
              r.direction = heading_up;
              r.run_steps = STEP_W'(diff > 0 ? diff : -diff);
              move_start = kept_pos;
              kept_pos = STEP_W'(goal);
            end
          end else if ((kept_pos < move_start) != (goal < int'(move_start))) begin
            // Target crossed the start point of the running motion.
            r.command = CMD_STOP;
            stop_pending = 1'b1;
          end
        end
        if (span == 0) r.percent = '0;
        else if (int'(kept_pos) > span) r.percent = PCT_FULL;
        else r.percent = PCT_W'(int'(kept_pos) * 200 / span);
        r.percent_valid = 1'b1;
      end
    endcase
    return r;
  endfunction

  // Offer one tick word; valid stays high after the handshake so that a
  // back-to-back word needs no second assignment in the same step.
  task automatic offer_tick(input logic signed [TGT_W-1:0] tgt, input logic busy,
                            input logic [STEP_W-1:0] done, input logic sw,
                            output tick_result_t res);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.target_position <= tgt;
    in_ch.motor_busy      <= busy;
    in_ch.executed_steps  <= done;
    in_ch.throttle_switch <= sw;
    do @(posedge clk); while (!in_ch.ready);
    res = track_tick(tgt, busy, done, sw);
    awaited.push_back(res);
    ticks_sent++;
    if (res.command == CMD_STOP) stops_issued++;
  endtask

  // Travel register write, only with the block drained and idle.
  task automatic write_travel(input logic [TOT_W-1:0] value);
    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    travel = value;
    cfg_we <= 1'b0;
    travel_writes++;
  endtask

  // Homing at full travel, then waiting while busy, then into tracking.
  task automatic test_homing();
    tick_result_t res;
    write_travel(12'd4095);
    offer_tick(TGT_W'($urandom_range(0, 16'hFFFF)), 1'b1, '0,
               1'($urandom_range(0, 1)), res);
    offer_tick(16'sd50, 1'b1, 13'd100, 1'b0, res);
    offer_tick(16'sd50, 1'b1, 13'd8191, 1'b1, res);
    offer_tick(16'sd50, 1'b0, '0, 1'b0, res);
  endtask

  // Targets at the limits of the field are clamped to 0..travel.
  task automatic test_clamping();
    tick_result_t res;
    offer_tick(16'sh7FFF, 1'b0, '0, 1'b0, res);
    offer_tick(16'sh7FFF, 1'b1, 13'd10, 1'b1, res);
    offer_tick(-16'sh8000, 1'b0, 13'd4095, 1'b0, res);
    offer_tick(16'sd0, 1'b0, '0, 1'b1, res);
    offer_tick(16'sd1, 1'b0, '0, 1'b0, res);
  endtask

  // Reversal while busy: stop, then rebuild, saturating high, low and in range.
  task automatic test_stop_and_rebuild();
    tick_result_t res;
    write_travel(12'd700);
    offer_tick(16'sd300, 1'b0, '0, 1'b0, res);
    offer_tick(16'sd500, 1'b0, '0, 1'b0, res);
    offer_tick(16'sd100, 1'b1, 13'd50, 1'b0, res);    // stop
    offer_tick(16'sd100, 1'b1, 13'd60, 1'b0, res);    // still stopping
    offer_tick(16'sd100, 1'b0, 13'd8191, 1'b0, res);  // rebuild saturates high
    offer_tick(16'sd200, 1'b0, '0, 1'b0, res);
    offer_tick(16'sd150, 1'b0, '0, 1'b0, res);
    offer_tick(16'sd250, 1'b1, 13'd20, 1'b1, res);    // stop while moving down
    offer_tick(16'sd250, 1'b0, 13'd8191, 1'b1, res);  // rebuild saturates low
    offer_tick(16'sd600, 1'b0, '0, 1'b0, res);
    offer_tick(16'sd100, 1'b1, 13'd90, 1'b0, res);    // stop
    offer_tick(16'sd100, 1'b0, 13'd120, 1'b0, res);   // rebuild in range
  endtask

  // Smallest, zero and largest travel, then travel cut below the position.
  task automatic test_travel_extremes();
    tick_result_t res;
    write_travel(12'd1);
    offer_tick(16'sd5, 1'b0, '0, 1'b0, res);
    write_travel(12'd0);
    offer_tick(16'sd3, 1'b0, '0, 1'b0, res);
    write_travel(12'd4095);
    offer_tick(16'sh7FFF, 1'b0, '0, 1'b1, res);
    write_travel(12'd100);
    offer_tick(16'sd50, 1'b1, 13'd30, 1'b0, res);     // percent pinned at 200
  endtask

  // Random motion: the busy flag mostly follows the commands the block gives,
  // executed counts mostly fit the last run; some words are plain noise.
  task automatic test_random_motion(input logic [TOT_W-1:0] setting, input int count,
                                    input bit no_gaps, input int stall_len);
    tick_result_t res;
    logic signed [TGT_W-1:0] tgt;
    logic busy;
    logic [STEP_W-1:0] done;
    int busy_left;
    int last_run;
    int pick;
    write_travel(setting);
    steady = no_gaps;
    hold_len = stall_len;
    busy_left = 0;
    last_run = 0;
    tgt = '0;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) tgt = TGT_W'($urandom_range(0, 16'hFFFF));
      else if (pick < 70) tgt = TGT_W'(int'($urandom_range(0, int'(setting) + 40)) - 20);
      busy = busy_left > 0;
      if (pick % 17 == 0) busy = ~busy;
      done = (pick % 10 == 3) ? STEP_W'($urandom_range(0, 8191))
                              : STEP_W'($urandom_range(0, last_run + 4));
      offer_tick(tgt, busy, done, 1'($urandom_range(0, 1)), res);
      if (busy_left > 0) busy_left--;
      if (res.command == CMD_RUN) begin
        busy_left = $urandom_range(0, 5);
        last_run = int'(res.run_steps);
      end else if (res.command == CMD_STOP) begin
        busy_left = $urandom_range(0, 2);
      end
    end
    steady = 1'b0;
  endtask

  // Receiver: random stall before each word, plus the one long hold.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 3);
      stall += hold_len;
      hold_len = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Compare every accepted result word with the oldest expectation.
  always @(posedge clk) begin : result_check
    tick_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (awaited.size() == 0) begin
        $error("result word with no tick outstanding");
        fail_count++;
      end else begin
        want = awaited.pop_front();
        if (out_ch.command !== want.command) begin
          $error("command: expected %0d, got %0d", want.command, out_ch.command);
          fail_count++;
        end
        if (out_ch.direction !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, out_ch.direction);
          fail_count++;
        end
        if (out_ch.run_steps !== want.run_steps) begin
          $error("run_steps: expected %0d, got %0d", want.run_steps, out_ch.run_steps);
          fail_count++;
        end
        if (out_ch.percent_position !== want.percent) begin
          $error("percent_position: expected %0d, got %0d", want.percent,
                 out_ch.percent_position);
          fail_count++;
        end
        if (out_ch.percent_valid !== want.percent_valid) begin
          $error("percent_valid: expected %0d, got %0d", want.percent_valid,
                 out_ch.percent_valid);
          fail_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.target_position = '0;
    in_ch.motor_busy = 1'b0;
    in_ch.executed_steps = '0;
    in_ch.throttle_switch = 1'b0;
    steady = 1'b0;
    hold_len = 0;
    mdl_phase = PH_HOME;
    kept_pos = '0;
    move_start = '0;
    stop_pending = 1'b0;
    heading_up = 1'b0;
    travel = TOTAL_RESET;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_homing();
    test_clamping();
    test_stop_and_rebuild();
    test_travel_extremes();
    test_random_motion(12'd700, 80, 1'b0, 0);
    test_random_motion(12'd4095, 80, 1'b0, 0);
    test_random_motion(12'd1, 40, 1'b0, 0);
    test_random_motion(TOT_W'($urandom_range(2, 4094)), 80, 1'b1, 0);
    test_random_motion(TOT_W'($urandom_range(1, 64)), 80, 1'b0, 150);
    test_random_motion(TOT_W'($urandom_range(1, 4095)), 90, 1'b0, 0);

    in_ch.valid <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d ticks and %0d result words over %0d travel settings,",
             ticks_sent, words_seen, travel_writes);
    $display("with homing, clamping, %0d reversal stops and a long receiver stall.",
             stops_issued);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
